@@ src/vncl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vncl_pkg
// Shared types and constants of the vertex lighting pipeline: beat formats,
// register indexes, matrix row layout and the divide-by-six constants.
// ----------------------------------------------------------------------------
package vncl_pkg;

	localparam int FRAC_BITS_DEF = 12;
	localparam int CFG_W         = 48;
	localparam int CFG_IDX_W     = 3;

	// fixed-point divide by six: d * RECIP >> SHIFT, exact for d below 2^DIV_W
	localparam int              DIV_W       = 19;
	localparam int              RECIP_W     = 22;
	localparam int              DIV6_SHIFT  = 24;
	localparam logic [RECIP_W-1:0] DIV6_RECIP = 22'd2796203;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LIGHT_X     = 3'd0,
		REG_LIGHT_Y     = 3'd1,
		REG_LIGHT_Z     = 3'd2,
		REG_COLOR_RED   = 3'd3,
		REG_COLOR_GREEN = 3'd4,
		REG_COLOR_BLUE  = 3'd5,
		REG_BACK_COLOR  = 3'd6
	} reg_idx_t;

	typedef logic signed [15:0] word_t;
	typedef word_t [2:0] row_t;

	typedef struct packed {
		logic signed [15:0] normal_x;
		logic signed [15:0] normal_y;
		logic signed [15:0] normal_z;
		logic [7:0]         vert_red;
		logic [7:0]         vert_green;
		logic [7:0]         vert_blue;
		logic               last_in;
	} in_beat_t;

	typedef struct packed {
		logic [15:0] lit_red;
		logic [15:0] lit_green;
		logic [15:0] lit_blue;
		logic        last_out;
	} out_beat_t;

	typedef struct packed {
		logic en_s5;
		logic en_s6;
		logic en_s7;
		logic en_s8;
	} curve_adv_t;

endpackage

@@ src/vertex_normal_color_lighting.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_normal_color_lighting
// Per-vertex lighting: normal through the light matrix, color matrix plus
// back color, vertex color scaling and a two-segment output curve.
// ----------------------------------------------------------------------------
// usage
//   in_valid/in_stall/in_data carry one vertex per beat (normal, color, last)
//   out_valid/out_stall/out_data carry one lit color per beat, in order
//   cfg_we/cfg_index/cfg_data write the seven 48-bit matrix and color registers;
//   write only while no vertex is in flight, index seven is ignored
// timing
//   eight register stages: a beat accepted into stage 1 is offered from stage 8
//   and leaves once out_stall is low
//   one vertex per clock unless out_stall holds; the stage count is set by the
//   two matrix products, vertex color multiply and divide by six of the curve
// stall
//   each stage holds while the one after it is full and held, so bubbles fill
//   up under out_stall and in_stall rises only when all eight stages are full
// reset
//   arst_n clears the configuration registers and empties the pipeline
// ----------------------------------------------------------------------------
module vertex_normal_color_lighting #(
	parameter int FRAC_BITS = vncl_pkg::FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  vncl_pkg::in_beat_t             in_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output vncl_pkg::out_beat_t            out_data,
	input  logic                           cfg_we,
	input  logic [vncl_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [vncl_pkg::CFG_W-1:0]     cfg_data
);

	localparam int NSTAGE = 8;
	localparam int P1_W   = 32;
	localparam int S1_W   = 34;
	localparam int L_W    = S1_W - FRAC_BITS;
	localparam int P2_W   = 16 + L_W;
	localparam int S2_W   = P2_W + 2;
	localparam int D_W    = S2_W - FRAC_BITS;
	localparam int C_W    = D_W + 1;
	localparam int MAG_W  = C_W;

	localparam logic signed [S1_W-1:0] HALF1 = S1_W'(64'sd1 << (FRAC_BITS - 1));
	localparam logic signed [S2_W-1:0] HALF2 = S2_W'(64'sd1 << (FRAC_BITS - 1));

	vncl_pkg::row_t light_q [3];
	vncl_pkg::row_t color_q [3];
	vncl_pkg::row_t back_q;

	logic [NSTAGE:1]   vld_q;
	logic [NSTAGE+1:1] rdy;
	logic [NSTAGE:1]   vld_prev;

	vncl_pkg::word_t [2:0] nvec;
	logic [2:0][7:0]       vert_in;

	logic signed [P1_W-1:0] p1_s1 [3][3];
	logic [2:0][7:0]        vert_s1, vert_s2, vert_s3, vert_s4;
	logic                   last_s1, last_s2, last_s3, last_s4;
	logic                   last_s5, last_s6, last_s7, last_s8;

	logic signed [S1_W-1:0] sum1 [3];
	logic signed [S1_W-1:0] sh1 [3];
	logic signed [L_W-1:0]  lv_s2 [3];

	logic signed [P2_W-1:0] p2_s3 [3][3];

	logic signed [S2_W-1:0] sum2 [3];
	logic signed [S2_W-1:0] sh2 [3];
	logic signed [C_W-1:0]  cval [3];
	logic [MAG_W-1:0]       mag_s4 [3];

	logic [2:0][15:0]     lit;
	vncl_pkg::curve_adv_t adv;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 3; r++) begin
				light_q[r] <= '0;
				color_q[r] <= '0;
			end
			back_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				vncl_pkg::REG_LIGHT_X:     light_q[0] <= cfg_data;
				vncl_pkg::REG_LIGHT_Y:     light_q[1] <= cfg_data;
				vncl_pkg::REG_LIGHT_Z:     light_q[2] <= cfg_data;
				vncl_pkg::REG_COLOR_RED:   color_q[0] <= cfg_data;
				vncl_pkg::REG_COLOR_GREEN: color_q[1] <= cfg_data;
				vncl_pkg::REG_COLOR_BLUE:  color_q[2] <= cfg_data;
				vncl_pkg::REG_BACK_COLOR:  back_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage handshake: a stage loads when empty or when the next one moves
	always_comb begin
		rdy[NSTAGE+1] = !out_stall;
		for (int k = NSTAGE; k >= 1; k--) begin
			rdy[k] = !vld_q[k] || rdy[k+1];
		end
	end

	assign vld_prev = {vld_q[NSTAGE-1:1], in_valid};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 1; k <= NSTAGE; k++) begin
				if (rdy[k]) begin
					vld_q[k] <= vld_prev[k];
				end
			end
		end
	end

	assign in_stall  = !rdy[1];
	assign out_valid = vld_q[NSTAGE];

	// stage 1: normal times light matrix, partial products
	assign nvec    = {in_data.normal_z, in_data.normal_y, in_data.normal_x};
	assign vert_in = {in_data.vert_blue, in_data.vert_green, in_data.vert_red};

	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			for (int r = 0; r < 3; r++) begin
				for (int k = 0; k < 3; k++) begin
					p1_s1[r][k] <= $signed(light_q[r][k]) * $signed(nvec[k]);
				end
			end
			vert_s1 <= vert_in;
			last_s1 <= in_data.last_in;
		end
	end

	// stage 2: light vector, rounded
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			sum1[r] = S1_W'(p1_s1[r][0]) + S1_W'(p1_s1[r][1]) + S1_W'(p1_s1[r][2]) + HALF1;
			sh1[r]  = sum1[r] >>> FRAC_BITS;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[2]) begin
			for (int r = 0; r < 3; r++) begin
				lv_s2[r] <= sh1[r][L_W-1:0];
			end
			vert_s2 <= vert_s1;
			last_s2 <= last_s1;
		end
	end

	// stage 3: color matrix times light vector, partial products
	always_ff @(posedge clk) begin
		if (rdy[3]) begin
			for (int c = 0; c < 3; c++) begin
				for (int k = 0; k < 3; k++) begin
					p2_s3[c][k] <= P2_W'($signed(color_q[c][k])) * P2_W'(lv_s2[k]);
				end
			end
			vert_s3 <= vert_s2;
			last_s3 <= last_s2;
		end
	end

	// stage 4: round, add back color, magnitude
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			sum2[c] = S2_W'(p2_s3[c][0]) + S2_W'(p2_s3[c][1]) + S2_W'(p2_s3[c][2]) + HALF2;
			sh2[c]  = sum2[c] >>> FRAC_BITS;
			cval[c] = C_W'($signed(sh2[c][D_W-1:0])) + C_W'($signed(back_q[c]));
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[4]) begin
			for (int c = 0; c < 3; c++) begin
				mag_s4[c] <= cval[c][C_W-1] ? MAG_W'(-cval[c]) : MAG_W'(cval[c]);
			end
			vert_s4 <= vert_s3;
			last_s4 <= last_s3;
		end
	end

	// stages 5 to 8: per-channel curve
	assign adv.en_s5 = rdy[5];
	assign adv.en_s6 = rdy[6];
	assign adv.en_s7 = rdy[7];
	assign adv.en_s8 = rdy[8];

	for (genvar ch = 0; ch < 3; ch++) begin : g_chan
		vncl_curve #(
			.FRAC_BITS(FRAC_BITS),
			.MAG_W    (MAG_W)
		) u_curve (
			.clk (clk),
			.adv (adv),
			.mag (mag_s4[ch]),
			.vert(vert_s4[ch]),
			.lit (lit[ch])
		);
	end

	always_ff @(posedge clk) begin
		if (rdy[5]) begin
			last_s5 <= last_s4;
		end
		if (rdy[6]) begin
			last_s6 <= last_s5;
		end
		if (rdy[7]) begin
			last_s7 <= last_s6;
		end
		if (rdy[8]) begin
			last_s8 <= last_s7;
		end
	end

	assign out_data.lit_red   = lit[0];
	assign out_data.lit_green = lit[1];
	assign out_data.lit_blue  = lit[2];
	assign out_data.last_out  = last_s8;

endmodule

@@ src/vncl_curve.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vncl_curve
// One color channel, stages five to eight: scale the magnitude by the vertex
// factor, round, then the two-segment curve with saturation at the top.
// ----------------------------------------------------------------------------
module vncl_curve #(
	parameter int FRAC_BITS = vncl_pkg::FRAC_BITS_DEF,
	parameter int MAG_W     = 31
) (
	input  logic                 clk,
	input  vncl_pkg::curve_adv_t adv,
	input  logic [MAG_W-1:0]     mag,
	input  logic [7:0]           vert,
	output logic [15:0]          lit
);

	localparam int M_W     = MAG_W + 2;
	localparam int PROD_W  = MAG_W + 8;
	localparam int QUARTER = 1 << (FRAC_BITS - 2);
	localparam int HALF    = 1 << (FRAC_BITS - 1);
	localparam int SAT_LIM = 6 * (65536 - HALF);
	localparam int M_LIM   = SAT_LIM + QUARTER - 3;
	localparam int DP_W    = vncl_pkg::DIV_W + vncl_pkg::RECIP_W;

	logic [PROD_W-1:0]          prod_s5;
	logic [PROD_W:0]            rsum;
	logic [M_W-1:0]             m;
	logic                       small_s6, sat_s6;
	logic [vncl_pkg::DIV_W-1:0] d_s6;
	logic [15:0]                twom_s6;
	logic [DP_W-1:0]            dprod_s7;
	logic                       small_s7, sat_s7;
	logic [15:0]                twom_s7;
	logic [15:0]                quot;
	logic [15:0]                lit_s8;

	always_ff @(posedge clk) begin
		if (adv.en_s5) begin
			prod_s5 <= PROD_W'(mag) * PROD_W'(vert);
		end
	end

	assign rsum = {1'b0, prod_s5} + (PROD_W + 1)'(64);
	assign m    = rsum[PROD_W:7];

	always_ff @(posedge clk) begin
		if (adv.en_s6) begin
			small_s6 <= (m <= M_W'(QUARTER));
			sat_s6   <= (m >= M_W'(M_LIM));
			d_s6     <= vncl_pkg::DIV_W'(m - M_W'(QUARTER) + M_W'(3));
			twom_s6  <= 16'({m, 1'b0});
		end
	end

	always_ff @(posedge clk) begin
		if (adv.en_s7) begin
			dprod_s7 <= DP_W'(d_s6) * DP_W'(vncl_pkg::DIV6_RECIP);
			small_s7 <= small_s6;
			sat_s7   <= sat_s6;
			twom_s7  <= twom_s6;
		end
	end

	assign quot = dprod_s7[vncl_pkg::DIV6_SHIFT +: 16];

	always_ff @(posedge clk) begin
		if (adv.en_s8) begin
			priority if (sat_s7) begin
				lit_s8 <= 16'hFFFF;
			end else if (small_s7) begin
				lit_s8 <= twom_s7;
			end else begin
				lit_s8 <= 16'(HALF) + quot;
			end
		end
	end

	assign lit = lit_s8;

endmodule
